### src/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants of the Diophantine solution counter.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam int COEF_BITS = 32;
    localparam logic [31:0] COEF_MASK = 32'hFFFF_FFFF >> (32 - COEF_BITS);

    localparam int DIV_BITS = 64;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ZZ_MUL,
        S_ZZ_FIN,
        S_ONE_DIV,
        S_GCD_PRE,
        S_GCD_U,
        S_GCD_LOOP,
        S_DIV_C,
        S_DIV_A,
        S_DIV_B,
        S_X0_CR,
        S_INV_R1,
        S_INV_Q,
        S_INV_MUL,
        S_INV_MOD,
        S_X0_MUL,
        S_X0_MOD,
        S_XHI_CHK,
        S_XHI_DIV,
        S_BN_MUL,
        S_LO_CHK,
        S_LO_DIV,
        S_RANGE,
        S_CU_HI,
        S_CU_LO,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quo;
        logic [DIV_BITS-1:0] rem;
    } t_div_rsp;

endpackage

### src/dsc_div.sv
// ----------------------------------------------------------------------------
// dsc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsc_div
    import dsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_BITS-1:0]     r_rem, r_quo, r_den;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_busy, r_done;

    logic [DIV_BITS:0] trial;
    logic [DIV_BITS:0] diff;
    logic              ge;

    assign trial = {r_rem, r_quo[DIV_BITS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so the kept bits suffice.
            r_rem <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

### src/diophantine_solution_counter_unit.sv
// ----------------------------------------------------------------------------
// diophantine_solution_counter_unit
// Counts the pairs 1 <= x, y <= n with a*x + b*y = c.
// ----------------------------------------------------------------------------
// One item is processed at a time and the input is not ready meanwhile. The
// cost is set by the shared 64-bit divider, on which every dividing state waits.
// Both coefficients zero need no division, and a single coefficient of zero
// needs one. The general case runs a binary gcd, up to ten fixed divisions,
// and two divisions per step of the Euclidean inverse (at most about 46 steps).
// A finished result waits in an output register, so the next item may be taken
// while it is pending.
module diophantine_solution_counter_unit
    import dsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_coef_a,
    input  logic [31:0] i_coef_b,
    input  logic [63:0] i_rhs,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_solution_count,
    output logic        o_solvable,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [31:0] r_range;
    logic [31:0] r_a, r_b, r_u, r_v, r_g, r_ar, r_br, r_crm;
    logic [31:0] r_r0, r_r1, r_t0, r_t1, r_q, r_x0, r_xhi;
    logic [63:0] r_cmag, r_cr, r_prod, r_bn, r_xlo, r_acc;
    logic [4:0]  r_sh;
    logic        r_neg, r_solv, r_wait;
    logic [31:0] r_count;
    logic        r_out_valid;
    logic [31:0] r_sol_count;
    logic        r_solvable;

    logic [31:0] n_a, n_b, n_u, n_v, n_g, n_ar, n_br, n_crm;
    logic [31:0] n_r0, n_r1, n_t0, n_t1, n_q, n_x0, n_xhi;
    logic [63:0] n_cmag, n_cr, n_prod, n_bn, n_xlo, n_acc;
    logic [4:0]  n_sh;
    logic        n_neg, n_solv, n_wait;
    logic [31:0] n_count;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [31:0] a_in, b_in;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic        is_div, skip, div_fin;
    logic        u_gt_v;
    logic [31:0] gdiff;
    logic [32:0] inv_sum;
    logic [31:0] inv_nt;
    logic [63:0] xlo_m1;

    dsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign a_in   = i_coef_a & COEF_MASK;
    assign b_in   = i_coef_b & COEF_MASK;
    assign u_gt_v = r_u > r_v;
    assign gdiff  = u_gt_v ? r_u - r_v : r_v - r_u;
    assign xlo_m1 = r_xlo - 64'd1;

    // (t0 + m - p) lies below 2m, so one conditional subtract reduces it.
    assign inv_sum = {1'b0, r_t0} + {1'b0, r_br} - {1'b0, div_rsp.rem[31:0]};
    assign inv_nt  = (inv_sum >= {1'b0, r_br}) ? 32'(inv_sum - {1'b0, r_br})
                                               : inv_sum[31:0];

    always_comb begin
        unique case (r_state)
            S_ZZ_MUL:  begin mul_x = r_range; mul_y = r_range; end
            S_INV_MUL: begin mul_x = r_q;     mul_y = r_t1;    end
            S_X0_MUL:  begin mul_x = r_crm;   mul_y = r_t0;    end
            default:   begin mul_x = r_br;    mul_y = r_range; end
        endcase
    end
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    always_comb begin
        is_div = 1'b1;
        skip   = 1'b0;
        div_req.num = r_cmag;
        div_req.den = {32'd0, r_g};
        unique case (r_state)
            S_ONE_DIV: div_req.den = {32'd0, r_a | r_b};
            S_DIV_C:   ;
            S_DIV_A:   div_req.num = {32'd0, r_a};
            S_DIV_B:   div_req.num = {32'd0, r_b};
            S_X0_CR:   begin div_req.num = r_cr;           div_req.den = {32'd0, r_br}; end
            S_INV_R1:  begin div_req.num = {32'd0, r_ar};  div_req.den = {32'd0, r_br}; end
            S_INV_Q:   begin div_req.num = {32'd0, r_r0};  div_req.den = {32'd0, r_r1}; end
            S_INV_MOD: begin div_req.num = r_prod;         div_req.den = {32'd0, r_br}; end
            S_X0_MOD:  begin div_req.num = r_prod;         div_req.den = {32'd0, r_br}; end
            S_XHI_DIV: begin
                div_req.num = r_cr - {32'd0, r_br};
                div_req.den = {32'd0, r_ar};
            end
            S_LO_DIV: begin
                div_req.num = r_cr - r_bn + {32'd0, r_ar} - 64'd1;
                div_req.den = {32'd0, r_ar};
            end
            S_CU_HI: begin
                div_req.num = {32'd0, r_xhi - r_x0};
                div_req.den = {32'd0, r_br};
                skip        = r_xhi < r_x0;
            end
            S_CU_LO: begin
                div_req.num = xlo_m1 - {32'd0, r_x0};
                div_req.den = {32'd0, r_br};
                skip        = xlo_m1 < {32'd0, r_x0};
            end
            default: is_div = 1'b0;
        endcase
        div_req.start = is_div && !r_wait && !skip;
    end

    assign div_fin = is_div && r_wait && div_rsp.done;
    assign n_wait  = div_req.start ? 1'b1 : (div_fin ? 1'b0 : r_wait);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (a_in == 32'd0 && b_in == 32'd0) n_state = S_ZZ_MUL;
                    else if (a_in == 32'd0 || b_in == 32'd0) n_state = S_ONE_DIV;
                    else n_state = S_GCD_PRE;
                end
            end
            S_ZZ_MUL:  n_state = S_ZZ_FIN;
            S_ZZ_FIN:  n_state = S_FIN;
            S_ONE_DIV: if (div_fin) n_state = S_FIN;
            S_GCD_PRE: if (r_u[0] | r_v[0]) n_state = S_GCD_U;
            S_GCD_U:   if (r_u[0]) n_state = S_GCD_LOOP;
            S_GCD_LOOP: begin
                if (r_v[0] && !u_gt_v && gdiff == 32'd0) n_state = S_DIV_C;
            end
            S_DIV_C: begin
                if (div_fin) begin
                    if (div_rsp.rem != 64'd0 || r_neg || r_cmag == 64'd0) n_state = S_FIN;
                    else n_state = S_DIV_A;
                end
            end
            S_DIV_A: if (div_fin) n_state = S_DIV_B;
            S_DIV_B: begin
                if (div_fin) n_state = (div_rsp.quo > 64'd1) ? S_X0_CR : S_XHI_CHK;
            end
            S_X0_CR:  if (div_fin) n_state = S_INV_R1;
            S_INV_R1: begin
                if (div_fin) n_state = (div_rsp.rem != 64'd0) ? S_INV_Q : S_X0_MUL;
            end
            S_INV_Q:   if (div_fin) n_state = S_INV_MUL;
            S_INV_MUL: n_state = S_INV_MOD;
            S_INV_MOD: if (div_fin) n_state = (r_r1 != 32'd0) ? S_INV_Q : S_X0_MUL;
            S_X0_MUL:  n_state = S_X0_MOD;
            S_X0_MOD:  if (div_fin) n_state = S_XHI_CHK;
            S_XHI_CHK: n_state = (r_cr < {32'd0, r_br}) ? S_FIN : S_XHI_DIV;
            S_XHI_DIV: if (div_fin) n_state = S_BN_MUL;
            S_BN_MUL:  n_state = S_LO_CHK;
            S_LO_CHK:  n_state = (r_cr > r_bn) ? S_LO_DIV : S_RANGE;
            S_LO_DIV:  if (div_fin) n_state = S_RANGE;
            S_RANGE:   n_state = (r_xlo <= {32'd0, r_xhi}) ? S_CU_HI : S_FIN;
            S_CU_HI:   if (skip || div_fin) n_state = S_CU_LO;
            S_CU_LO:   if (skip || div_fin) n_state = S_FIN;
            S_FIN:     if (!r_out_valid || i_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_a = r_a;   n_b = r_b;   n_u = r_u;   n_v = r_v;   n_g = r_g;
        n_ar = r_ar; n_br = r_br; n_crm = r_crm;
        n_r0 = r_r0; n_r1 = r_r1; n_t0 = r_t0; n_t1 = r_t1; n_q = r_q;
        n_x0 = r_x0; n_xhi = r_xhi;
        n_cmag = r_cmag; n_cr = r_cr; n_prod = r_prod; n_bn = r_bn;
        n_xlo = r_xlo; n_acc = r_acc; n_sh = r_sh;
        n_neg = r_neg; n_solv = r_solv; n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                n_a    = a_in;
                n_b    = b_in;
                n_u    = a_in;
                n_v    = b_in;
                n_sh   = '0;
                n_neg  = i_rhs[63];
                n_cmag = i_rhs[63] ? (64'd0 - i_rhs) : i_rhs;
                n_count = '0;
                n_solv  = 1'b0;
                n_x0    = '0;
                n_xlo   = 64'd1;
            end
            S_ZZ_MUL: n_prod = mul_p;
            S_ZZ_FIN: begin
                n_solv = r_cmag == 64'd0;
                if (r_cmag == 64'd0) begin
                    n_count = (r_prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r_prod[31:0];
                end
            end
            S_ONE_DIV: begin
                if (div_fin) begin
                    n_solv = div_rsp.rem == 64'd0;
                    if (div_rsp.rem == 64'd0 && !r_neg && r_cmag != 64'd0
                        && div_rsp.quo <= {32'd0, r_range}) n_count = r_range;
                end
            end
            S_GCD_PRE: begin
                if (!(r_u[0] | r_v[0])) begin
                    n_u  = r_u >> 1;
                    n_v  = r_v >> 1;
                    n_sh = r_sh + 5'd1;
                end
            end
            S_GCD_U: if (!r_u[0]) n_u = r_u >> 1;
            S_GCD_LOOP: begin
                if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else begin
                    // Keep the smaller value in u and the difference in v.
                    if (u_gt_v) n_u = r_v;
                    n_v = gdiff;
                    n_g = r_u << r_sh;
                end
            end
            S_DIV_C: begin
                if (div_fin) begin
                    n_cr   = div_rsp.quo;
                    n_solv = div_rsp.rem == 64'd0;
                end
            end
            S_DIV_A:  if (div_fin) n_ar = div_rsp.quo[31:0];
            S_DIV_B:  if (div_fin) n_br = div_rsp.quo[31:0];
            S_X0_CR:  if (div_fin) n_crm = div_rsp.rem[31:0];
            S_INV_R1: begin
                if (div_fin) begin
                    n_r0 = r_br;
                    n_r1 = div_rsp.rem[31:0];
                    n_t0 = 32'd0;
                    n_t1 = 32'd1;
                end
            end
            S_INV_Q: begin
                if (div_fin) begin
                    // The quotient reaches the modulus only when it is
                    // congruent to zero.
                    n_q  = (div_rsp.quo == {32'd0, r_br}) ? 32'd0 : div_rsp.quo[31:0];
                    n_r0 = r_r1;
                    n_r1 = div_rsp.rem[31:0];
                end
            end
            S_INV_MUL: n_prod = mul_p;
            S_INV_MOD: begin
                if (div_fin) begin
                    n_t0 = r_t1;
                    n_t1 = inv_nt;
                end
            end
            S_X0_MUL:  n_prod = mul_p;
            S_X0_MOD:  if (div_fin) n_x0 = div_rsp.rem[31:0];
            S_XHI_DIV: begin
                if (div_fin) begin
                    n_xhi = (div_rsp.quo > {32'd0, r_range}) ? r_range : div_rsp.quo[31:0];
                end
            end
            S_BN_MUL: n_bn = mul_p;
            S_LO_DIV: begin
                if (div_fin && div_rsp.quo > 64'd1) n_xlo = div_rsp.quo;
            end
            S_CU_HI: begin
                if (skip) n_acc = 64'd0;
                else if (div_fin) n_acc = div_rsp.quo + 64'd1;
            end
            S_CU_LO: begin
                if (skip) n_count = r_acc[31:0];
                else if (div_fin) n_count = 32'(r_acc - div_rsp.quo - 64'd1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_range     <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            if (i_cfg_valid) r_range <= i_cfg_data;
            if (r_state == S_FIN && (!r_out_valid || i_ready)) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;   r_b <= n_b;   r_u <= n_u;   r_v <= n_v;   r_g <= n_g;
        r_ar <= n_ar; r_br <= n_br; r_crm <= n_crm;
        r_r0 <= n_r0; r_r1 <= n_r1; r_t0 <= n_t0; r_t1 <= n_t1; r_q <= n_q;
        r_x0 <= n_x0; r_xhi <= n_xhi;
        r_cmag <= n_cmag; r_cr <= n_cr; r_prod <= n_prod; r_bn <= n_bn;
        r_xlo <= n_xlo; r_acc <= n_acc; r_sh <= n_sh;
        r_neg <= n_neg; r_solv <= n_solv; r_count <= n_count;
        if (r_state == S_FIN && (!r_out_valid || i_ready)) begin
            r_sol_count <= r_count;
            r_solvable  <= r_solv;
        end
    end

    assign o_ready          = r_state == S_IDLE;
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_solution_count = r_sol_count;
    assign o_solvable       = r_solvable;

endmodule

### src/dsc_checker.sv
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks of the Diophantine solution counter.
// ----------------------------------------------------------------------------
module dsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_solution_count,
    input logic        o_solvable
);

    // A pending result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_solution_count) && $stable(o_solvable))
        else $error("pending result changed");

    // An equation without solutions never reports a count.
    a_unsolv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_solvable |-> o_solution_count == 32'd0)
        else $error("count reported for unsolvable item");

    // The unit is busy right after it takes an item.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an accepted item");

endmodule

bind diophantine_solution_counter_unit dsc_checker u_dsc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_solution_count (o_solution_count),
    .o_solvable       (o_solvable)
);

### sim/diophantine_solution_counter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diophantine_solution_counter_checker
// Watches the item, result and register channels of the counter, predicts
// the count and the solvable flag of every accepted item, and compares each
// result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module diophantine_solution_counter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_coef_a,
    input  logic [31:0] i_coef_b,
    input  logic [63:0] i_rhs,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [31:0] i_solution_count,
    input  logic        i_solvable,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] count;
        logic        solvable;
    } t_answer;

    t_answer     answer_q[$];
    logic [31:0] limit_n;

    function automatic logic [63:0] gcd_of(logic [63:0] u, logic [63:0] v);
        int unsigned sh;
        logic [63:0] t;
        sh = 0;
        if (u == 0) return v;
        if (v == 0) return u;
        while (((u | v) & 1) == 0) begin
            u = u >> 1;
            v = v >> 1;
            sh++;
        end
        while ((u & 1) == 0) u = u >> 1;
        do begin
            while ((v & 1) == 0) v = v >> 1;
            if (u > v) begin
                t = u;
                u = v;
                v = t;
            end
            v = v - u;
        end while (v != 0);
        return u << sh;
    endfunction

    function automatic logic [63:0] inverse_mod(logic [63:0] a, logic [63:0] m);
        logic [63:0] r0, r1, t0, t1, q, nr, nt;
        r0 = m;
        r1 = a % m;
        t0 = 0;
        t1 = 1 % m;
        while (r1 != 0) begin
            q  = r0 / r1;
            nr = r0 - q * r1;
            nt = (t0 + m - ((q % m) * t1) % m) % m;
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        return t0;
    endfunction

    // Number of values in [0, v] that are congruent to x0 modulo m.
    function automatic logic [63:0] residues_upto(logic [63:0] v, logic [63:0] x0,
                                                  logic [63:0] m);
        if (v < x0) return 0;
        return (v - x0) / m + 1;
    endfunction

    function automatic t_answer count_pairs(logic [31:0] ca, logic [31:0] cb,
                                            logic [63:0] c, logic [31:0] lim);
        t_answer     ans;
        logic [63:0] a, b, n, cmag, cnt, g, ar, br, cr, x0, xlo, xhi, bn, lo;
        logic        neg;
        a    = {32'd0, ca & dsc_pkg::COEF_MASK};
        b    = {32'd0, cb & dsc_pkg::COEF_MASK};
        n    = {32'd0, lim};
        neg  = c[63];
        cmag = neg ? -c : c;
        cnt  = 0;
        ans.solvable = 1'b0;
        if (a == 0 && b == 0) begin
            ans.solvable = (c == 0);
            if (ans.solvable) begin
                cnt = n * n;
                if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
            end
        end else if (a == 0 || b == 0) begin
            ans.solvable = (cmag % (a | b)) == 0;
            if (ans.solvable && !neg && cmag != 0 && cmag / (a | b) <= n) cnt = n;
        end else begin
            g = gcd_of(a, b);
            ans.solvable = (cmag % g) == 0;
            if (ans.solvable && !neg && cmag != 0) begin
                ar  = a / g;
                br  = b / g;
                cr  = cmag / g;
                x0  = 0;
                xlo = 1;
                if (br > 1) x0 = ((cr % br) * inverse_mod(ar, br)) % br;
                // y >= 1 bounds x from above, y <= n bounds it from below.
                if (cr >= br) begin
                    xhi = (cr - br) / ar;
                    if (xhi > n) xhi = n;
                    bn = br * n;
                    if (cr > bn) begin
                        lo = (cr - bn + ar - 1) / ar;
                        if (lo > xlo) xlo = lo;
                    end
                    if (xlo <= xhi)
                        cnt = residues_upto(xhi, x0, br) - residues_upto(xlo - 1, x0, br);
                end
            end
        end
        ans.count = cnt[31:0];
        return ans;
    endfunction

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            limit_n = 32'd1;
            answer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) limit_n = i_cfg_data;
            if (i_valid && i_in_ready)
                answer_q.push_back(count_pairs(i_coef_a, i_coef_b, i_rhs, limit_n));
            if (i_out_valid && i_ready) begin
                if (answer_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: result count=%0d solvable=%0b with no item pending",
                                 i_solution_count, i_solvable);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (want.count !== i_solution_count || want.solvable !== i_solvable) begin
                        if (o_fail_count < 10)
                            $display("ERROR: expected count=%0d solvable=%0b, got %0d %0b",
                                     want.count, want.solvable, i_solution_count, i_solvable);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### sim/diophantine_solution_counter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diophantine_solution_counter_unit_test
// Drives directed and random equations through the counter under several
// range limits, with random gaps on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module diophantine_solution_counter_unit_test;

    localparam int WATCHDOG_CYCLES = 100000;
    localparam int LONG_HOLD       = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_coef_a;
    logic [31:0] i_coef_b;
    logic [63:0] i_rhs;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_solution_count;
    logic        o_solvable;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic        hold_rx;
    logic [31:0] limit_n;

    diophantine_solution_counter_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_coef_a         (i_coef_a),
        .i_coef_b         (i_coef_b),
        .i_rhs            (i_rhs),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_solution_count (o_solution_count),
        .o_solvable       (o_solvable),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    diophantine_solution_counter_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_in_ready       (o_ready),
        .i_coef_a         (i_coef_a),
        .i_coef_b         (i_coef_b),
        .i_rhs            (i_rhs),
        .i_out_valid      (o_valid),
        .i_ready          (i_ready),
        .i_solution_count (o_solution_count),
        .i_solvable       (o_solvable),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_equation(logic [31:0] a, logic [31:0] b, logic [63:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_rhs    <= c;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // The block is idle once every result is back; the register is then written.
    task automatic write_limit(logic [31:0] n);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_n = n;
    endtask

    function automatic logic [31:0] random_coef();
        logic [31:0] v;
        v = $urandom >> $urandom_range(0, 31);
        return (v == 0) ? 32'd1 : v;
    endfunction

    // Mostly equations built from a pair in range, so that counts are nonzero.
    task automatic send_random_equation();
        logic [31:0] a, b, x, y;
        logic [63:0] c;
        int          r;
        r = $urandom_range(0, 99);
        a = random_coef();
        b = random_coef();
        if ($urandom_range(0, 1)) begin
            a = $urandom_range(1, 50);
            b = $urandom_range(1, 50);
        end
        x = $urandom_range(1, limit_n);
        y = $urandom_range(1, limit_n);
        c = 64'(a) * 64'(x) + 64'(b) * 64'(y);
        if (r < 15) c = {$urandom, $urandom};
        else if (r < 25) c = c + 64'($signed($urandom_range(0, 6)) - 3);
        else if (r < 30) c = -c;
        send_equation(a, b, c);
    endtask

    initial begin
        logic [31:0] limits[5];
        limits = '{32'd100, 32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd7};
        limits[3] = $urandom | 32'd1;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_coef_a    <= '0;
        i_coef_b    <= '0;
        i_rhs       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        hold_rx      = 1'b0;
        limit_n      = 32'd1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limit of one: only x = y = 1 can fit.
        send_equation(32'd1, 32'd1, 64'd2);
        send_equation(32'd3, 32'd5, 64'd8);
        send_equation(32'd3, 32'd5, 64'd9);
        write_limit(32'd10);
        send_equation(32'd4, 32'd6, 64'd7);
        send_equation(32'd4, 32'd6, 64'd40);
        send_equation(32'd2, 32'd3, 64'd0);
        send_equation(32'd2, 32'd3, -64'sd12);
        send_equation(32'd1, 32'd1, 64'h8000_0000_0000_0000);
        send_equation(32'd1, 32'd1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_equation(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0000_0001_FFFF_FFFE);
        send_equation(32'hFFFF_FFFF, 32'hFFFF_FFFE, 64'h0000_0009_FFFF_FFF0);
        send_equation(32'd7, 32'd7, 64'd14);
        send_equation(32'd1, 32'd2, 64'd1);
        write_limit(32'hFFFF_FFFF);
        send_equation(32'd1, 32'd1, 64'h0000_0001_FFFF_FFFE);
        send_equation(32'd1, 32'd1, 64'd3);
        send_equation(32'hFFFF_FFFF, 32'd1, 64'hFFFF_FFFF_0000_0000);
        send_equation(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFE_0000_0002);
        send_equation(32'h8000_0000, 32'h4000_0000, 64'h0000_0000_C000_0000);

        foreach (limits[p]) begin
            write_limit(limits[p]);
            // One phase runs against a long receiver stall so the block backs up.
            if (p == 1) hold_rx = 1'b1;
            repeat (54) send_random_equation();
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int r;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_rx) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_rx = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    i_ready <= 1'b0;
                    repeat ($urandom_range(30, 300)) @(posedge i_clk);
                end else if (r < 25) begin
                    i_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
